// ===== hdl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants of the positional list engine: beat payloads,
// mode codes and the command broadcast to every storage cell
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the beats
    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] length;
        logic             empty_res;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [IDX_W-1:0]      tgt;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  rd_start;
        logic                  rd_hit_en;
    } t_cell_cmd;

endpackage

// ===== hdl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one storage slot of the list: holds one word, shifts with its neighbors
// on insert and remove, and carries the read word along the chain
// ----------------------------------------------------------------------------
module ple_cell (
    input  logic                           i_clk,
    input  logic [ple_pkg::IDX_W-1:0]      i_idx,
    input  ple_pkg::t_cell_cmd             i_cmd,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_left_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_right_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_left_rd,
    output logic [ple_pkg::DATA_WIDTH-1:0] o_data,
    output logic [ple_pkg::DATA_WIDTH-1:0] o_rd
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [DATA_WIDTH-1:0] r_rd, n_rd;
    logic                  at_tgt, past_tgt;

    assign at_tgt   = (i_idx == i_cmd.tgt);
    assign past_tgt = (i_idx > i_cmd.tgt);

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (past_tgt) begin
                    n_data = i_left_data;
                end else if (at_tgt) begin
                    n_data = i_cmd.wdata;
                end
            end
            CELL_REMOVE: begin
                if (at_tgt || past_tgt) begin
                    n_data = i_right_data;
                end
            end
            CELL_WRITE: begin
                if (at_tgt) begin
                    n_data = i_cmd.wdata;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // read word travels toward the far end, one cell a cycle
    always_comb begin
        if (i_cmd.rd_start) begin
            n_rd = (i_cmd.rd_hit_en && at_tgt) ? r_data : '0;
        end else begin
            n_rd = r_rd | i_left_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_rd   <= n_rd;
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

// ===== hdl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of data words addressed by one-based position, stored in a
// chain of cells that shift in parallel on insert and remove
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready    | t_in_item  (mode, position, value)
//  out     | output    | o_out_valid / i_out_ready  | t_out_item (ok, read_value, length, empty_res)
//
//  insert, remove, overwrite, clear and unused modes finish at the edge that
//  accepts the beat; the result is valid in the next cycle
//  a read's word rides the cell chain one cell a cycle out to the last
//  cell, where it is picked up
//  one request is in flight at a time; a new beat is taken when the output
//  register is empty or is being emptied in the same cycle
//  reset (synchronous, active low) empties the list and the output register;
//  cell contents are not cleared and are unreachable until written
//
module positional_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ple_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ple_pkg::t_out_item o_out_data
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_rd_cnt, n_rd_cnt;
    logic                  r_rd_ok, n_rd_ok;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext, cnt_ext;
    logic                  pos_nz, in_range, ins_ok;
    logic                  req_ok;
    logic                  rd_done;
    t_cell_cmd             cmd;

    // chain wiring: one data output per cell; the read chain has one extra
    // slot ahead of the first cell, tied to zero
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY+1];

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // position checks against the current length
    assign pos_ext  = CMP_W'(i_in_data.position);
    assign cnt_ext  = CMP_W'(r_count);
    assign pos_nz   = (i_in_data.position != '0);
    assign in_range = pos_nz && (pos_ext <= cnt_ext);
    assign ins_ok   = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1))
                      && (cnt_ext < CMP_W'(CAPACITY));

    always_comb begin
        unique case (i_in_data.mode)
            MODE_INSERT: req_ok = ins_ok;
            MODE_REMOVE: req_ok = in_range;
            MODE_READ:   req_ok = in_range;
            MODE_WRITE:  req_ok = in_range;
            MODE_CLEAR:  req_ok = 1'b1;
            default:     req_ok = 1'b0;
        endcase
    end

    // command broadcast to every cell
    always_comb begin
        cmd           = '0;
        cmd.op        = CELL_HOLD;
        cmd.tgt       = IDX_W'(pos_ext - CMP_W'(1));
        cmd.wdata     = DATA_WIDTH'(i_in_data.value);
        cmd.rd_start  = accept && (i_in_data.mode == MODE_READ);
        cmd.rd_hit_en = req_ok;
        if (accept && req_ok) begin
            unique case (i_in_data.mode)
                MODE_INSERT: cmd.op = CELL_INSERT;
                MODE_REMOVE: cmd.op = CELL_REMOVE;
                MODE_WRITE:  cmd.op = CELL_WRITE;
                default:     cmd.op = CELL_HOLD;
            endcase
        end
    end

    assign cell_rd[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;

            // cell 0 has no left neighbor, the last cell no right neighbor
            assign left_data  = (g == 0) ? '0 : cell_data[(g == 0) ? 0 : g - 1];
            assign right_data = (g == CAPACITY - 1) ? '0
                                : cell_data[(g == CAPACITY - 1) ? g : g + 1];

            ple_cell u_cell (
                .i_clk        (i_clk),
                .i_idx        (IDX_W'(g)),
                .i_cmd        (cmd),
                .i_left_data  (left_data),
                .i_right_data (right_data),
                .i_left_rd    (cell_rd[g]),
                .o_data       (cell_data[g]),
                .o_rd         (cell_rd[g + 1])
            );
        end
    endgenerate

    // read word has reached the last cell once the shift counter reaches the last cell index
    assign rd_done = (r_state == ST_READ) && (r_rd_cnt == IDX_W'(CAPACITY - 1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_cnt    = r_rd_cnt;
        n_rd_ok     = r_rd_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.mode == MODE_READ) begin
                        n_state  = ST_READ;
                        n_rd_cnt = '0;
                        n_rd_ok  = req_ok;
                    end else begin
                        if (req_ok) begin
                            unique case (i_in_data.mode)
                                MODE_INSERT: n_count = r_count + CNT_W'(1);
                                MODE_REMOVE: n_count = r_count - CNT_W'(1);
                                MODE_CLEAR:  n_count = '0;
                                default:     n_count = r_count;
                            endcase
                        end
                        n_out.ok         = req_ok;
                        n_out.read_value = '0;
                        n_out.length     = LEN_W'(n_count);
                        n_out.empty_res  = (n_count == '0);
                        n_out_valid      = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (rd_done) begin
                    n_state          = ST_IDLE;
                    n_out.ok         = r_rd_ok;
                    n_out.read_value = VAL_W'(cell_rd[CAPACITY]);
                    n_out.length     = LEN_W'(r_count);
                    n_out.empty_res  = (r_count == '0);
                    n_out_valid      = 1'b1;
                end else begin
                    n_rd_cnt = r_rd_cnt + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_cnt    <= n_rd_cnt;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // the list never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("list length above capacity");

    // a read in flight leaves the length alone
    a_read_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_count == $past(r_count)))
        else $error("length changed during a read");

    // while a read rides the chain the output register is empty
    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("result pending while a read is in flight");

    // empty flag agrees with the reported length
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.empty_res == (r_out.length == '0)))
        else $error("empty flag disagrees with length");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the positional list engine against a shadow list kept in the
// bench: every accepted request updates the shadow and queues the reply it
// should produce, and every reply beat is compared field by field with the
// oldest queued one; a short table of hand-picked requests runs first,
// followed by random episodes that grow, shrink or churn the list
// ----------------------------------------------------------------------------
module testbench;

    import ple_pkg::*;

    // modes the engine does not decode; they must be rejected untouched
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int PROBE_ROWS   = 25;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int PAUSE_AT     = 900;   // sender waits for a full drain here
    localparam int DRAIN_LIMIT  = 20000;

    // sender episodes steer the list toward full, toward empty, or churn it
    typedef enum logic [1:0] {
        EP_GROW,
        EP_SHRINK,
        EP_MIXED
    } t_episode;

    // receiver stall styles
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_TOGGLE
    } t_sink_style;

    // one row of the directed table: request, whether the reply is typed in,
    // and the typed reply
    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_probe_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // shadow of the list contents and length
    logic [DATA_WIDTH-1:0] list_words [CAPACITY];
    int                    list_len = 0;

    // replies still owed by the engine, oldest first
    t_out_item awaited_replies [$];

    int fail_count   = 0;
    int replies_seen = 0;
    int mode_hits [8];
    int rejects      = 0;
    int full_rejects = 0;
    int peak_len     = 0;

    // long hold-off requests from the sender side, served by the receiver
    int hold_asks    = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    t_sink_style sink_style = SINK_OPEN;
    int          sink_left  = 0;

    positional_list_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // shadow list: applies one request and returns the reply it must give
    // ------------------------------------------------------------------------
    function automatic t_out_item apply_list_request(input t_in_item req);
        t_out_item res;
        int        pos;
        int        i;
        res = '0;
        pos = req.position;
        case (req.mode)
            MODE_INSERT: begin
                // room left and position 1..len+1; later entries move up
                if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
                    for (i = list_len; i >= pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos-1] = req.value[DATA_WIDTH-1:0];
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                // later entries move down, the slot past the new end is zeroed
                if (pos >= 1 && pos <= list_len) begin
                    for (i = pos; i < list_len; i++)
                        list_words[i-1] = list_words[i];
                    list_len--;
                    list_words[list_len] = '0;
                    res.ok = 1'b1;
                end
            end
            MODE_READ: begin
                if (pos >= 1 && pos <= list_len) begin
                    res.read_value = VAL_W'(list_words[pos-1]);
                    res.ok         = 1'b1;
                end
            end
            MODE_WRITE: begin
                if (pos >= 1 && pos <= list_len) begin
                    list_words[pos-1] = req.value[DATA_WIDTH-1:0];
                    res.ok            = 1'b1;
                end
            end
            MODE_CLEAR: begin
                // words stay in storage but fall out of reach
                list_len = 0;
                res.ok   = 1'b1;
            end
            default: begin
                // unused modes: rejected, nothing moves
            end
        endcase
        res.length    = LEN_W'(list_len);
        res.empty_res = (list_len == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    // row whose reply is read off directly
    function automatic t_probe_row typed_row(
        input logic [MODE_W-1:0] mode,
        input logic [POS_W-1:0]  position,
        input logic [VAL_W-1:0]  value,
        input logic              ok,
        input logic [VAL_W-1:0]  read_value,
        input logic [LEN_W-1:0]  length
    );
        t_probe_row row;
        row.req        = {mode, position, value};
        row.typed      = 1'b1;
        row.want       = {ok, read_value, length, length == '0};
        return row;
    endfunction

    // row left to the shadow list
    function automatic t_probe_row shadow_row(
        input logic [MODE_W-1:0] mode,
        input logic [POS_W-1:0]  position,
        input logic [VAL_W-1:0]  value
    );
        t_probe_row row;
        row       = '0;
        row.req   = {mode, position, value};
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic t_probe_row probe_row(input int idx);
        t_probe_row row;
        row = '0;
        case (idx)
            // empty list: every access is a bad position
            0:  row = typed_row(MODE_READ,    7'd1,   32'h0,        1'b0, 32'h0, 7'd0);
            1:  row = typed_row(MODE_REMOVE,  7'd1,   32'h0,        1'b0, 32'h0, 7'd0);
            2:  row = typed_row(MODE_WRITE,   7'd1,   32'hDEADBEEF, 1'b0, 32'h0, 7'd0);
            // insert at position zero, one past len+1, and the top position
            3:  row = typed_row(MODE_INSERT,  7'd0,   32'h1,        1'b0, 32'h0, 7'd0);
            4:  row = typed_row(MODE_INSERT,  7'd2,   32'h2,        1'b0, 32'h0, 7'd0);
            5:  row = typed_row(MODE_INSERT,  7'd127, 32'h3,        1'b0, 32'h0, 7'd0);
            // build the list with extreme words, at head and tail
            6:  row = typed_row(MODE_INSERT,  7'd1,   32'hFFFFFFFF, 1'b1, 32'h0, 7'd1);
            7:  row = typed_row(MODE_INSERT,  7'd1,   32'h00000000, 1'b1, 32'h0, 7'd2);
            8:  row = typed_row(MODE_INSERT,  7'd3,   32'hA5A5A5A5, 1'b1, 32'h0, 7'd3);
            9:  row = shadow_row(MODE_INSERT, 7'd2,   32'h12345678);
            10: row = shadow_row(MODE_READ,   7'd1,   32'hFFFFFFFF);
            11: row = shadow_row(MODE_READ,   7'd4,   32'h0);
            // reads past the end
            12: row = typed_row(MODE_READ,    7'd5,   32'h0,        1'b0, 32'h0, 7'd4);
            13: row = typed_row(MODE_READ,    7'd127, 32'h0,        1'b0, 32'h0, 7'd4);
            14: row = shadow_row(MODE_WRITE,  7'd4,   32'h5A5A5A5A);
            15: row = shadow_row(MODE_READ,   7'd4,   32'h0);
            16: row = typed_row(MODE_WRITE,   7'd0,   32'h77777777, 1'b0, 32'h0, 7'd4);
            // remove from the middle, then look at what moved in
            17: row = shadow_row(MODE_REMOVE, 7'd2,   32'h0);
            18: row = shadow_row(MODE_READ,   7'd2,   32'h0);
            19: row = typed_row(MODE_REMOVE,  7'd4,   32'h0,        1'b0, 32'h0, 7'd3);
            // unused modes are rejected
            20: row = typed_row(MODE_SPARE_5, 7'd1,   32'h0,        1'b0, 32'h0, 7'd3);
            21: row = typed_row(MODE_SPARE_7, 7'd127, 32'hFFFFFFFF, 1'b0, 32'h0, 7'd3);
            // clear always succeeds, and nothing is reachable afterwards
            22: row = typed_row(MODE_CLEAR,   7'd0,   32'h0,        1'b1, 32'h0, 7'd0);
            23: row = typed_row(MODE_READ,    7'd1,   32'h0,        1'b0, 32'h0, 7'd0);
            24: row = shadow_row(MODE_SPARE_6, 7'd64, 32'h0);
            default: row = '0;
        endcase
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers one beat and holds it until the engine takes it; the
    // shadow is updated at the accepting edge so the next beat sees fresh state
    // ------------------------------------------------------------------------
    task automatic push_request(input t_in_item req, input logic typed,
                                input t_out_item typed_reply);
        t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        if (req.mode == MODE_INSERT && list_len == CAPACITY)
            full_rejects++;
        predicted = apply_list_request(req);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        mode_hits[req.mode]++;
        if (!predicted.ok)
            rejects++;
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    // ------------------------------------------------------------------------
    // receiver: stall pattern of its own, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_asks) begin
            // hold the output closed long enough for the engine to back up
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_style <= t_sink_style'($urandom_range(0, 3));
                sink_left  <= $urandom_range(4, 60);
            end else begin
                sink_left <= sink_left - 1;
            end
            case (sink_style)
                SINK_OPEN:   i_out_ready <= 1'b1;
                SINK_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                SINK_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:     i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // reply checker: each reply beat against the oldest awaited reply
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_check
        t_out_item want;
        if (i_rst_n && $isunknown(o_out_valid)) begin
            $display("%0t: out valid is unknown", $time);
            fail_count++;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply beat with nothing awaited, got %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_out_data.ok !== want.ok) begin
                    $display("%0t: ok mismatch, expected %b got %b",
                             $time, want.ok, o_out_data.ok);
                    fail_count++;
                end
                if (o_out_data.read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch, expected %h got %h",
                             $time, want.read_value, o_out_data.read_value);
                    fail_count++;
                end
                if (o_out_data.length !== want.length) begin
                    $display("%0t: length mismatch, expected %0d got %0d",
                             $time, want.length, o_out_data.length);
                    fail_count++;
                end
                if (o_out_data.empty_res !== want.empty_res) begin
                    $display("%0t: empty_res mismatch, expected %b got %b",
                             $time, want.empty_res, o_out_data.empty_res);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_probe_row row;
        t_in_item   req;
        t_episode   ep_style;
        int         ep_left;
        int         burst_left;
        int         steady_left;
        int         gap;
        int         issued;
        int         roll;
        int         pick;
        int         span;
        int         pos;
        int         waited;
        int         k;

        for (k = 0; k < 8; k++)
            mode_hits[k] = 0;
        for (k = 0; k < CAPACITY; k++)
            list_words[k] = '0;
        ep_style    = EP_GROW;
        ep_left     = 0;
        burst_left  = 0;
        steady_left = 0;
        issued      = 0;

        // reset held low at the start, then released once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, back to back beats
        for (k = 0; k < PROBE_ROWS; k++) begin
            row = probe_row(k);
            push_request(row.req, row.typed, row.want);
        end

        // random episodes
        while (issued < RANDOM_ITEMS) begin
            // idle before this beat: a full drain at set points, else burst gaps
            if ((issued == 0 || issued == PAUSE_AT) && awaited_replies.size() != 0) begin
                i_in_valid <= 1'b0;
                while (awaited_replies.size() != 0)
                    @(posedge i_clk);
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = (steady_left > 0) ? 0 : $urandom_range(0, 10);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end

            // long receiver hold-off while the sender keeps offering beats
            if (issued == 500 || issued == 1200) begin
                hold_asks++;
                steady_left = 30;
            end

            if (ep_left == 0) begin
                ep_style = t_episode'($urandom_range(0, 2));
                ep_left  = $urandom_range(20, 150);
            end

            roll      = $urandom_range(0, 99);
            req.value = $urandom;
            if (roll < 4) begin
                // noise: any mode, any position
                req.mode     = MODE_W'($urandom_range(0, 7));
                req.position = POS_W'($urandom_range(0, 127));
            end else if (roll < 6) begin
                req.mode     = MODE_CLEAR;
                req.position = POS_W'($urandom_range(0, 127));
            end else begin
                pick = $urandom_range(0, 99);
                case (ep_style)
                    EP_GROW:   req.mode = (pick < 70) ? MODE_INSERT :
                                          (pick < 80) ? MODE_READ :
                                          (pick < 90) ? MODE_WRITE : MODE_REMOVE;
                    EP_SHRINK: req.mode = (pick < 15) ? MODE_INSERT :
                                          (pick < 30) ? MODE_READ :
                                          (pick < 45) ? MODE_WRITE : MODE_REMOVE;
                    default:   req.mode = (pick < 30) ? MODE_INSERT :
                                          (pick < 55) ? MODE_READ :
                                          (pick < 75) ? MODE_WRITE : MODE_REMOVE;
                endcase
                // legal span of positions, weighted toward its ends, with rare positions outside it
                span = (req.mode == MODE_INSERT) ? list_len + 1 : list_len;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    pos = $urandom_range(span + 1, 127);
                else if (pick == 1)
                    pos = 0;
                else if (pick <= 4)
                    pos = 1;
                else if (pick <= 7)
                    pos = (span < 1) ? 1 : span;
                else
                    pos = $urandom_range(1, (span < 1) ? 1 : span);
                req.position = POS_W'(pos);
            end

            push_request(req, 1'b0, '0);
            issued++;
            ep_left--;
            burst_left--;
            if (steady_left > 0)
                steady_left--;
        end
        i_in_valid <= 1'b0;

        // drain, then give a slow read time to show any stray beat
        waited = 0;
        while (awaited_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (awaited_replies.size() != 0) begin
            $display("%0t: %0d awaited replies never arrived", $time, awaited_replies.size());
            fail_count += awaited_replies.size();
        end

        $display("covered %0d requests: insert %0d, remove %0d, read %0d, write %0d, clear %0d",
                 PROBE_ROWS + issued, mode_hits[MODE_INSERT], mode_hits[MODE_REMOVE],
                 mode_hits[MODE_READ], mode_hits[MODE_WRITE], mode_hits[MODE_CLEAR]);
        $display("rejected %0d (full list %0d), peak length %0d, %0d replies checked",
                 rejects, full_rejects, peak_len, replies_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
